>>> src/assert_macros.svh
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AST_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mvsm_pkg.sv
// Types, constants and the soft-clip table of the voice mixer.
package mvsm_pkg;

    localparam int NUM_VOICES_DEF   = 8;
    localparam int SAMPLE_DEPTH_DEF = 16384;
    localparam int CLIP_NODES       = 1024;
    localparam int DOUBLINGS        = 12;
    localparam int CLIP_LIMIT       = CLIP_NODES * 256;

    typedef enum logic [2:0] {
        REQ_WRITE  = 3'd0,
        REQ_BIND   = 3'd1,
        REQ_ENABLE = 3'd2,
        REQ_UNBIND = 3'd3,
        REQ_MIX    = 3'd4
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_CLIP0,
        S_CLIP1,
        S_CLIP2,
        S_CLIP3,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [2:0]         voice;
        logic [13:0]        address;
        logic [14:0]        length;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic               enable;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic [7:0]         active_mask;
    } t_out_item;

    typedef logic [15:0] t_clip_tbl [CLIP_NODES+1];

    // Restoring division, used only while the table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh node in Q1.15 from a cubic seed and repeated doubling.
    function automatic logic [15:0] node_value(input int k);
        logic [63:0] a;
        logic [63:0] a3;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] y;
        a  = ((64'(k) << 26) + 64'd16383) / 64'd32767;
        a3 = (((a * a) >> 30) * a) >> 30;
        t  = a - a3 / 64'd3;
        for (int i = 0; i < DOUBLINGS; i++) begin
            t2 = (t * t) >> 30;
            t  = udiv64(t << 31, (64'd1 << 30) + t2);
        end
        y = (t * 64'd32767 + (64'd1 << 29)) >> 30;
        return y[15:0];
    endfunction

    function automatic t_clip_tbl build_clip_tbl();
        t_clip_tbl tb;
        for (int k = 0; k <= CLIP_NODES; k++) begin
            tb[k] = node_value(k);
        end
        return tb;
    endfunction

    localparam t_clip_tbl CLIP_TBL = build_clip_tbl();

endpackage

>>> src/mvsm_ram.sv
// Generic single-port RAM with registered read.
module mvsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

>>> src/multi_voice_sample_mixer.sv
// Eight-voice stereo sample mixer with soft clipping over a shared sample RAM.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one request beat:
// write frame, bind voice, set enable, unbind voice or mix one frame.
// Every request gives exactly one result beat on the output channel
// (o_out_valid / i_out_ready / o_out_data); its active mask is taken after
// the request acted, and its samples are zero unless the request was a mix.
// A control request goes from accept straight to the finish step. A mix runs the
// voice scan and a drain step, then the clip unit when two or more voices
// played, and then its finish step: the voice scan issues one sample RAM read
// per voice per cycle, and the clip unit runs four steps per channel through
// the registered tanh table.
// One request is in work at a time; o_in_ready is high while the block idles.
// A finished result sits in an output register, so the next request is taken
// while that result waits; a stalled receiver holds the following result in
// the finish step and the input stays closed until it moves.
// Synchronous reset unbinds and disables all voices; the sample RAM keeps
// undefined contents until written. SAMPLE_DEPTH must be a power of two.
`include "assert_macros.svh"
module multi_voice_sample_mixer #(
    parameter int NUM_VOICES   = mvsm_pkg::NUM_VOICES_DEF,
    parameter int SAMPLE_DEPTH = mvsm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mvsm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mvsm_pkg::t_out_item o_out_data
);
    import mvsm_pkg::*;

    localparam int CW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int SW = 17 + $clog2(NUM_VOICES);

    t_state r_state, n_state;

    logic [13:0]            r_base [NUM_VOICES];
    logic [14:0]            r_len  [NUM_VOICES];
    logic [14:0]            r_pos  [NUM_VOICES];
    logic [NUM_VOICES-1:0]  r_en;
    logic [NUM_VOICES-1:0]  r_bound;

    logic [CW-1:0]          r_cnt;
    logic                   r_rd_act;
    logic signed [SW-1:0]   r_sum_l, r_sum_r;
    logic [1:0]             r_nplay;
    logic                   r_ch;
    logic                   r_neg;
    logic [7:0]             r_f;
    logic [10:0]            r_k;
    logic [15:0]            r_t0;
    logic [15:0]            r_tbl_q;
    logic [24:0]            r_p0, r_p1;
    logic signed [15:0]     r_res_l, r_res_r;
    logic                   r_out_vld;
    t_out_item              r_out;

    logic                   w_accept;
    logic [5:0]             w_vext;
    logic                   w_vok;
    logic [CW-1:0]          w_vi;
    logic                   w_act;
    logic [14:0]            w_pos_inc;
    logic [20:0]            w_wa, w_ra;
    logic                   w_ram_we;
    logic [AW-1:0]          w_ram_addr;
    logic [31:0]            w_ram_rdata;
    logic                   w_out_free;
    logic [NUM_VOICES+7:0]  w_mask_pad;
    logic signed [SW-1:0]   w_s;
    logic signed [SW:0]     w_sx, w_mag;
    logic [SW-1:0]          w_abs;
    logic [31:0]            w_abs32;
    logic [18:0]            w_u;
    logic [10:0]            w_kn;
    logic [10:0]            w_tbl_addr;
    logic [25:0]            w_ysum;
    logic [15:0]            w_y;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_vext    = {3'b000, i_in_data.voice};
    assign w_vok     = w_vext < 6'(NUM_VOICES);
    assign w_vi      = w_vext[CW-1:0];
    assign w_act     = r_bound[r_cnt] && r_en[r_cnt];
    assign w_pos_inc = r_pos[r_cnt] + 15'd1;
    assign w_wa      = 21'(i_in_data.address);
    assign w_ra      = 21'(r_base[r_cnt]) + 21'(r_pos[r_cnt]);
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_mask_pad = {8'b0, r_bound & r_en};

    // Clip datapath for the selected channel.
    assign w_s     = r_ch ? r_sum_r : r_sum_l;
    assign w_sx    = {w_s[SW-1], w_s};
    assign w_mag   = w_s[SW-1] ? -w_sx : w_sx;
    assign w_abs   = w_mag[SW-1:0];
    assign w_abs32 = 32'(w_abs);
    assign w_u     = (w_abs32 > 32'(CLIP_LIMIT)) ? 19'(CLIP_LIMIT) : w_abs32[18:0];
    assign w_kn    = (r_k == 11'(CLIP_NODES)) ? r_k : r_k + 11'd1;
    assign w_tbl_addr = (r_state == S_CLIP0) ? w_u[18:8] : w_kn;
    assign w_ysum  = 26'(r_p0) + 26'(r_p1);
    assign w_y     = w_ysum[23:8];

    mvsm_ram #(
        .WIDTH (32),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata ({i_in_data.right_in, i_in_data.left_in}),
        .o_rdata (w_ram_rdata)
    );

    // tanh table lookup with registered read
    always_ff @(posedge i_clk) begin
        r_tbl_q <= CLIP_TBL[w_tbl_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.req_type == REQ_MIX) ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (r_cnt == CW'(NUM_VOICES - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = (r_nplay == 2'd2) ? S_CLIP0 : S_FINISH;
            S_CLIP0:  n_state = S_CLIP1;
            S_CLIP1:  n_state = S_CLIP2;
            S_CLIP2:  n_state = S_CLIP3;
            S_CLIP3:  n_state = r_ch ? S_FINISH : S_CLIP0;
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_ram_we   = w_accept && (i_in_data.req_type == REQ_WRITE);
        w_ram_addr = w_ram_we ? w_wa[AW-1:0] : w_ra[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_en      <= '0;
            r_bound   <= '0;
            r_rd_act  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
            r_nplay   <= '0;
            r_ch      <= 1'b0;
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_base[v] <= '0;
                r_len[v]  <= '0;
                r_pos[v]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_rd_act <= (r_state == S_SCAN) && w_act;
            if (r_rd_act) begin
                r_sum_l <= r_sum_l + SW'(signed'(w_ram_rdata[15:0]));
                r_sum_r <= r_sum_r + SW'(signed'(w_ram_rdata[31:16]));
            end
            if (r_state == S_FINISH && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_sum_l <= '0;
                    r_sum_r <= '0;
                    r_nplay <= '0;
                    r_cnt   <= '0;
                    r_ch    <= 1'b0;
                    r_res_l <= '0;
                    r_res_r <= '0;
                    if (w_accept && w_vok) begin
                        case (i_in_data.req_type)
                            REQ_BIND: begin
                                r_base[w_vi]  <= i_in_data.address;
                                r_len[w_vi]   <= i_in_data.length;
                                r_pos[w_vi]   <= '0;
                                r_bound[w_vi] <= 1'b1;
                                r_en[w_vi]    <= (i_in_data.length != 15'd0);
                            end
                            REQ_ENABLE: begin
                                // finished voices stay off
                                if (r_bound[w_vi]) begin
                                    r_en[w_vi] <= i_in_data.enable &&
                                                  (r_pos[w_vi] < r_len[w_vi]);
                                end
                            end
                            REQ_UNBIND: begin
                                r_bound[w_vi] <= 1'b0;
                                r_en[w_vi]    <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_act) begin
                        r_pos[r_cnt] <= w_pos_inc;
                        r_en[r_cnt]  <= (w_pos_inc < r_len[r_cnt]);
                        if (r_nplay != 2'd2) begin
                            r_nplay <= r_nplay + 2'd1;
                        end
                    end
                    r_cnt <= r_cnt + CW'(1);
                end
                S_DRAIN: begin
                    // fold in the last voice's read, still in flight
                    r_res_l <= r_sum_l[15:0] + (r_rd_act ? w_ram_rdata[15:0] : 16'd0);
                    r_res_r <= r_sum_r[15:0] + (r_rd_act ? w_ram_rdata[31:16] : 16'd0);
                end
                S_CLIP0: begin
                    r_neg <= w_s[SW-1];
                    r_k   <= w_u[18:8];
                    r_f   <= w_u[7:0];
                end
                S_CLIP1: begin
                    r_t0 <= r_tbl_q;
                end
                S_CLIP2: begin
                    r_p0 <= 25'(r_t0 * (9'd256 - 9'(r_f)));
                    r_p1 <= 25'(r_tbl_q * 9'(r_f));
                end
                S_CLIP3: begin
                    if (r_ch) begin
                        r_res_r <= r_neg ? -signed'(w_y) : signed'(w_y);
                    end else begin
                        r_res_l <= r_neg ? -signed'(w_y) : signed'(w_y);
                    end
                    r_ch <= 1'b1;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out.out_left    <= r_res_l;
                        r_out.out_right   <= r_res_r;
                        r_out.active_mask <= w_mask_pad[7:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `AST_IMP(a_clip_multi, i_clk, i_rst_n, r_state == S_CLIP0, r_nplay == 2'd2, "clip without two voices")
    `AST_IMP(a_rd_phase, i_clk, i_rst_n, r_rd_act, r_state == S_SCAN || r_state == S_DRAIN, "stray sample read")
    `AST_NXT(a_scan_closed, i_clk, i_rst_n, r_state == S_SCAN, !o_in_ready, "input open during scan")

endmodule

>>> dv/tb.sv
// Self-checking bench for the eight-voice sample mixer: directed table, then random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mvsm_pkg::*;

    localparam int NV = 8;
    localparam int DEPTH = 16384;
    localparam int LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    multi_voice_sample_mixer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // predictor state
    logic [31:0] frame_mem [DEPTH];
    bit          frame_written [DEPTH];
    logic [13:0] vbase [NV];
    logic [14:0] vlen [NV];
    logic [14:0] vpos [NV];
    bit          ven [NV];
    bit          vbound [NV];
    logic [15:0] tanh_nodes [CLIP_NODES+1];

    t_out_item mix_expected [$];
    int        fails;
    int        cycles;
    int        sent_beats;

    function automatic logic [63:0] div64(input logic [63:0] n, input logic [63:0] d);
        return n / d;
    endfunction

    function automatic logic [15:0] tanh_node(input int k);
        logic [63:0] a, a3, t, t2;
        a  = ((64'(k) << 26) + 64'd16383) / 64'd32767;
        a3 = (((a * a) >> 30) * a) >> 30;
        t  = a - a3 / 64'd3;
        for (int i = 0; i < DOUBLINGS; i++) begin
            t2 = (t * t) >> 30;
            t  = div64(t << 31, (64'd1 << 30) + t2);
        end
        return 16'((t * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic int soft_limit(input int s);
        int u, k, f, y;
        u = (s < 0) ? -s : s;
        if (u > CLIP_LIMIT) u = CLIP_LIMIT;
        k = u >> 8;
        f = u & 255;
        if (k >= CLIP_NODES) y = tanh_nodes[CLIP_NODES];
        else y = (int'(tanh_nodes[k]) * (256 - f) + int'(tanh_nodes[k+1]) * f) >>> 8;
        return (s < 0) ? -y : y;
    endfunction

    function automatic logic [7:0] live_voices();
        logic [7:0] m = '0;
        for (int v = 0; v < NV; v++) m[v] = vbound[v] && ven[v];
        return m;
    endfunction

    function automatic t_out_item mix_predict(input t_in_item it);
        t_out_item r;
        int l, rr, played;
        logic [31:0] fr;
        l = 0; rr = 0; played = 0;
        case (it.req_type)
            REQ_WRITE: begin
                frame_mem[it.address] = {it.right_in, it.left_in};
                frame_written[it.address] = 1'b1;
            end
            REQ_BIND: begin
                vbase[it.voice] = it.address;
                vlen[it.voice] = it.length;
                vpos[it.voice] = '0;
                vbound[it.voice] = 1'b1;
                ven[it.voice] = it.length != 0;
            end
            REQ_ENABLE:
                if (vbound[it.voice]) ven[it.voice] = it.enable && vpos[it.voice] < vlen[it.voice];
            REQ_UNBIND: begin
                vbound[it.voice] = 1'b0;
                ven[it.voice] = 1'b0;
            end
            REQ_MIX:
                for (int c = 0; c < NV; c++) begin
                    if (vbound[c] && ven[c]) begin
                        fr = frame_mem[14'(vbase[c] + vpos[c])];
                        l += int'($signed(fr[15:0]));
                        rr += int'($signed(fr[31:16]));
                        played++;
                        vpos[c] = vpos[c] + 15'd1;
                        ven[c] = vpos[c] < vlen[c];
                    end
                end
            default: ;
        endcase
        if (played > 1) begin
            l = soft_limit(l);
            rr = soft_limit(rr);
        end
        r.out_left = 16'(l);
        r.out_right = 16'(rr);
        r.active_mask = live_voices();
        return r;
    endfunction

    // make sure every active voice reads only written frames
    function automatic bit mix_safe();
        for (int c = 0; c < NV; c++)
            if (vbound[c] && ven[c] && !frame_written[14'(vbase[c] + vpos[c])]) return 0;
        return 1;
    endfunction

    function automatic t_in_item make_req(input t_req rq, input int v, input int adr,
                                          input int len, input int l, input int r, input int en);
        t_in_item it;
        it.req_type = rq;
        it.voice = 3'(v);
        it.address = 14'(adr);
        it.length = 15'(len);
        it.left_in = 16'(l);
        it.right_in = 16'(r);
        it.enable = 1'(en);
        return it;
    endfunction

    // directed rows: request plus optional typed-in expectation
    typedef struct {
        t_in_item  req;
        bit        fixed;
        t_out_item want;
    } t_row;
    t_row rows [$];

    int burst_left;

    task automatic send_beat(input t_in_item it, input bit fixed, input t_out_item want);
        t_out_item p;
        // gaps between bursts
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!o_in_ready);
        p = mix_predict(it);
        if (fixed && p !== want) begin
            $display("%0t table row disagrees: expected %p predicted %p", $time, want, p);
            fails++;
        end
        mix_expected.push_back(p);
        sent_beats++;
    endtask

    // receiver stalls on its own pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (cycles % 512 < 128) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (mix_expected.size() == 0) begin
                $display("%0t unexpected beat: expected none actual %p", $time, o_out_data);
                fails++;
            end else begin
                e = mix_expected.pop_front();
                if (o_out_data.out_left !== e.out_left) begin
                    $display("%0t out_left: expected %0d actual %0d", $time, e.out_left,
                             o_out_data.out_left);
                    fails++;
                end
                if (o_out_data.out_right !== e.out_right) begin
                    $display("%0t out_right: expected %0d actual %0d", $time, e.out_right,
                             o_out_data.out_right);
                    fails++;
                end
                if (o_out_data.active_mask !== e.active_mask) begin
                    $display("%0t active_mask: expected %h actual %h", $time, e.active_mask,
                             o_out_data.active_mask);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic t_out_item res(input int l, input int r, input int m);
        t_out_item o;
        o.out_left = 16'(l);
        o.out_right = 16'(r);
        o.active_mask = 8'(m);
        return o;
    endfunction

    task automatic add_row(input t_in_item it, input bit fixed, input t_out_item want);
        t_row rw;
        rw.req = it;
        rw.fixed = fixed;
        rw.want = want;
        rows.push_back(rw);
    endtask

    task automatic rand_burst();
        int v, base, len, adr;
        t_out_item none;
        v = $urandom_range(0, NV - 1);
        base = $urandom_range(0, DEPTH - 1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 6);
        // write the frames a voice will read, then bind it
        for (int i = 0; i < len && i < 6; i++) begin
            adr = (base + i) % DEPTH;
            send_beat(make_req(REQ_WRITE, 0, adr, 0, $urandom, $urandom, 0), 0, none);
        end
        if (len > 6) len = 6 + ($urandom_range(0, 1) ? 0 : len % 3);
        if (len > 6)
            for (int i = 6; i < len; i++)
                send_beat(make_req(REQ_WRITE, 0, (base + i) % DEPTH, 0, $urandom, $urandom, 0),
                          0, none);
        send_beat(make_req(REQ_BIND, v, base, len, $urandom, $urandom, $urandom), 0, none);
    endtask

    initial begin
        t_in_item it;
        t_out_item none;
        int pick;
        fails = 0;
        cycles = 0;
        sent_beats = 0;
        burst_left = 0;
        none = res(0, 0, 0);
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        for (int k = 0; k <= CLIP_NODES; k++) tanh_nodes[k] = tanh_node(k);
        for (int i = 0; i < DEPTH; i++) frame_written[i] = 0;
        for (int v = 0; v < NV; v++) begin
            vbase[v] = '0; vlen[v] = '0; vpos[v] = '0; ven[v] = 0; vbound[v] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes: full-scale frames, address wrap, zero length, late enable
        add_row(make_req(REQ_MIX, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0));
        add_row(make_req(REQ_WRITE, 0, 16383, 0, 32767, -32768, 1), 1, res(0, 0, 0));
        add_row(make_req(REQ_WRITE, 0, 0, 0, -32768, 32767, 0), 1, res(0, 0, 0));
        add_row(make_req(REQ_WRITE, 0, 1, 0, 32767, 32767, 0), 1, res(0, 0, 0));
        add_row(make_req(REQ_ENABLE, 3, 0, 0, 0, 0, 1), 1, res(0, 0, 0));
        add_row(make_req(REQ_BIND, 0, 16383, 2, 0, 0, 0), 1, res(0, 0, 1));
        add_row(make_req(REQ_MIX, 0, 0, 0, 0, 0, 0), 1, res(32767, -32768, 1));
        add_row(make_req(REQ_BIND, 7, 0, 0, 0, 0, 0), 1, res(0, 0, 1));
        add_row(make_req(REQ_ENABLE, 7, 0, 0, 0, 0, 1), 1, res(0, 0, 1));
        add_row(make_req(REQ_BIND, 5, 16383, 16384, 0, 0, 0), 0, none);
        add_row(make_req(REQ_BIND, 6, 1, 1, 0, 0, 0), 0, none);
        add_row(make_req(REQ_MIX, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(REQ_MIX, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(REQ_ENABLE, 6, 0, 0, 0, 0, 1), 1, res(0, 0, 8'h20));
        add_row(make_req(REQ_ENABLE, 5, 0, 0, 0, 0, 0), 1, res(0, 0, 0));
        add_row(make_req(REQ_ENABLE, 5, 0, 0, 0, 0, 1), 1, res(0, 0, 8'h20));
        add_row(make_req(REQ_UNBIND, 5, 0, 0, 0, 0, 0), 1, res(0, 0, 0));
        add_row(make_req(t_req'(3'd5), 1, 0, 0, 0, 0, 1), 1, res(0, 0, 0));
        add_row(make_req(t_req'(3'd7), 2, 0, 0, 0, 0, 1), 1, res(0, 0, 0));
        foreach (rows[i]) send_beat(rows[i].req, rows[i].fixed, rows[i].want);

        while (sent_beats < 850) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                rand_burst();
            end else if (pick < 85) begin
                if (mix_safe())
                    send_beat(make_req(REQ_MIX, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom), 0, none);
            end else begin
                // noise: writes, enables, unbinds, unknown types
                it = make_req(REQ_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
                case ($urandom_range(0, 3))
                    0: it.req_type = REQ_WRITE;
                    1: it.req_type = REQ_ENABLE;
                    2: it.req_type = REQ_UNBIND;
                    default: it.req_type = 3'($urandom_range(5, 7));
                endcase
                if (it.req_type == REQ_ENABLE) begin
                    // only re-enable where the next read is a written frame
                    if (!frame_written[14'(vbase[it.voice] + vpos[it.voice])]) it.enable = 0;
                end
                send_beat(it, 0, none);
            end
        end
        i_in_valid <= 1'b0;

        while (mix_expected.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/mvsm_pkg.sv
src/mvsm_ram.sv
src/multi_voice_sample_mixer.sv
dv/tb.sv
